>>> hw/rtl/lwbc_pkg.sv
// lwbc_pkg: shared widths, codes and payload types of the block cache
// used by every module under hw/rtl; depends on nothing
`default_nettype none

package lwbc_pkg;

    localparam int ID_BITS        = 10;
    localparam int DATA_BITS      = 64;
    localparam int CFG_BITS       = 5;
    localparam int SYNC_BITS      = 5;
    localparam int CACHE_LINES_DF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_BITS-1:0]  LINES_RESET = CFG_BITS'(16);
    localparam logic [SYNC_BITS-1:0] SYNC_MAX    = '1;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_SYNC  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_LOOKUP,
        ST_ACT,
        ST_FILL,
        ST_SYNC
    } state_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [ID_BITS-1:0]   blk_num;
        logic [DATA_BITS-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 hit;
        logic                 evicted;
        logic [ID_BITS-1:0]   victim_id;
        logic                 victim_written;
        logic [SYNC_BITS-1:0] sync_count;
    } out_item_t;

    // decoded item as it sits in the queue
    typedef struct packed {
        cmd_t                 op;
        logic [ID_BITS-1:0]   id;
        logic [DATA_BITS-1:0] data;
    } qent_t;

    // queue handshake between front and back
    typedef struct packed {
        logic  valid;
        qent_t ent;
    } qhead_t;

endpackage

`default_nettype wire

>>> hw/rtl/lwbc_front.sv
// lwbc_front: input acceptance, command decode and the two-entry queue
// depends on lwbc_pkg
`default_nettype none

module lwbc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire lwbc_pkg::in_item_t in_data,
    input  wire logic              wiping,
    input  wire logic              pop,
    output lwbc_pkg::qhead_t       head
);
    import lwbc_pkg::*;

    qent_t      q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       wr_ptr_next, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, do_pop;
    qent_t      dec;

    always_comb
    begin
        case (in_data.command)
            CMD_READ:  dec.op = CMD_READ;
            CMD_WRITE: dec.op = CMD_WRITE;
            CMD_CLEAR: dec.op = CMD_CLEAR;
            default:   dec.op = CMD_SYNC;
        endcase
        dec.id   = in_data.blk_num;
        dec.data = in_data.write_data;
    end

    assign in_stall = wiping || (cnt_reg == 2'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (cnt_reg != 2'd0);

    assign wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
    assign cnt_next    = cnt_reg + 2'(push) - 2'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.ent   = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> hw/rtl/lwbc_back.sv
// lwbc_back: line lookup, lru update, fill and write-back sequencer with the backing store
// depends on lwbc_pkg
`default_nettype none

module lwbc_back #(
    parameter int CACHE_LINES = lwbc_pkg::CACHE_LINES_DF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lwbc_pkg::qhead_t         head,
    output logic                          pop,
    output logic                          wiping,
    input  wire logic [lwbc_pkg::CFG_BITS-1:0] lines_cfg,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output lwbc_pkg::out_item_t           out_data
);
    import lwbc_pkg::*;

    localparam int LW = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
    localparam int UW = $clog2(CACHE_LINES + 1);
    localparam int SD = 1 << ID_BITS;

    state_t state_reg, state_next;

    logic [ID_BITS-1:0]   tag_reg   [CACHE_LINES];
    logic                 valid_reg [CACHE_LINES];
    logic                 dirty_reg [CACHE_LINES];
    logic [LW-1:0]        rank_reg  [CACHE_LINES];
    logic [DATA_BITS-1:0] data_reg  [CACHE_LINES];
    logic [UW-1:0]        used_reg;

    logic [DATA_BITS-1:0] store_mem [SD];
    logic [DATA_BITS-1:0] store_rdata_reg;
    logic                 store_we;
    logic [ID_BITS-1:0]   store_waddr, store_raddr;
    logic [DATA_BITS-1:0] store_wdata;

    logic [ID_BITS-1:0]   wipe_idx_reg;
    logic [LW-1:0]        sync_idx_reg;
    logic [SYNC_BITS-1:0] sync_cnt_reg;
    qent_t                cur_reg;
    logic                 hit_reg, evict_reg;
    logic [LW-1:0]        slot_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    // lookup decode
    logic          hit_any;
    logic [LW-1:0] hit_idx, old_idx, slot_sel;
    logic [UW-1:0] limit;

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        old_idx = '0;
        for (int i = 0; i < CACHE_LINES; i++)
        begin
            if (valid_reg[i] && tag_reg[i] == cur_reg.id)
            begin
                hit_any = 1'b1;
                hit_idx = hit_idx | LW'(i);
            end
            // valid ranks form 0..used-1, so the oldest holds used-1
            if (valid_reg[i] && rank_reg[i] == LW'(used_reg - UW'(1)))
                old_idx = old_idx | LW'(i);
        end
        if (lines_cfg == '0)
            limit = UW'(1);
        else if (int'(lines_cfg) > CACHE_LINES)
            limit = UW'(CACHE_LINES);
        else
            limit = UW'(lines_cfg);
        if (hit_any)
            slot_sel = hit_idx;
        else if (used_reg >= limit)
            slot_sel = old_idx;
        else
            slot_sel = LW'(used_reg);
    end

    logic [DATA_BITS-1:0] fill_word;
    assign fill_word = hit_reg ? data_reg[slot_reg] : store_rdata_reg;

    logic load_out;

    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        store_we    = 1'b0;
        store_waddr = wipe_idx_reg;
        store_wdata = '0;
        store_raddr = cur_reg.id;
        load_out    = 1'b0;
        case (state_reg)
            ST_WIPE:
            begin
                store_we = 1'b1;
                if (wipe_idx_reg == ID_BITS'(SD - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (head.valid && !out_valid_reg)
                begin
                    pop        = 1'b1;
                    state_next = (head.ent.op == CMD_SYNC) ? ST_SYNC : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
                state_next = ST_ACT;
            ST_ACT:
            begin
                if (evict_reg && dirty_reg[slot_reg])
                begin
                    store_we    = 1'b1;
                    store_waddr = tag_reg[slot_reg];
                    store_wdata = data_reg[slot_reg];
                end
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SYNC:
            begin
                if (valid_reg[sync_idx_reg] && dirty_reg[sync_idx_reg])
                begin
                    store_we    = 1'b1;
                    store_waddr = tag_reg[sync_idx_reg];
                    store_wdata = data_reg[sync_idx_reg];
                end
                if (sync_idx_reg == LW'(CACHE_LINES - 1))
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= store_wdata;
        store_rdata_reg <= store_mem[store_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            wipe_idx_reg  <= '0;
            sync_idx_reg  <= '0;
            sync_cnt_reg  <= '0;
            used_reg      <= '0;
            hit_reg       <= 1'b0;
            evict_reg     <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CACHE_LINES; i++)
            begin
                tag_reg[i]   <= '0;
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_WIPE:
                    wipe_idx_reg <= wipe_idx_reg + ID_BITS'(1);
                ST_IDLE:
                begin
                    sync_idx_reg <= '0;
                    sync_cnt_reg <= '0;
                end
                ST_LOOKUP:
                begin
                    hit_reg   <= hit_any;
                    evict_reg <= !hit_any && (used_reg >= limit);
                    slot_reg  <= slot_sel;
                end
                ST_ACT:
                begin
                    for (int i = 0; i < CACHE_LINES; i++)
                    begin
                        if (LW'(i) != slot_reg && valid_reg[i] &&
                            (!(hit_reg || evict_reg) || rank_reg[i] < rank_reg[slot_reg]))
                            rank_reg[i] <= rank_reg[i] + LW'(1);
                    end
                    rank_reg[slot_reg] <= '0;
                    if (!hit_reg)
                    begin
                        valid_reg[slot_reg] <= 1'b1;
                        dirty_reg[slot_reg] <= 1'b0;
                        tag_reg[slot_reg]   <= cur_reg.id;
                        if (!evict_reg)
                            used_reg <= used_reg + UW'(1);
                    end
                end
                ST_FILL:
                begin
                    if (cur_reg.op != CMD_READ)
                        dirty_reg[slot_reg] <= 1'b1;
                    out_valid_reg <= 1'b1;
                end
                ST_SYNC:
                begin
                    if (valid_reg[sync_idx_reg] && dirty_reg[sync_idx_reg])
                    begin
                        dirty_reg[sync_idx_reg] <= 1'b0;
                        if (sync_cnt_reg != SYNC_MAX)
                            sync_cnt_reg <= sync_cnt_reg + SYNC_BITS'(1);
                    end
                    sync_idx_reg <= sync_idx_reg + LW'(1);
                    if (load_out)
                        out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    logic [SYNC_BITS-1:0] sync_final;
    assign sync_final = (valid_reg[sync_idx_reg] && dirty_reg[sync_idx_reg] &&
                         sync_cnt_reg != SYNC_MAX) ? sync_cnt_reg + SYNC_BITS'(1)
                                                   : sync_cnt_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head.ent;
        if (state_reg == ST_ACT)
        begin
            out_reg.victim_id      <= evict_reg ? tag_reg[slot_reg] : '0;
            out_reg.victim_written <= evict_reg && dirty_reg[slot_reg];
        end
        if (state_reg == ST_FILL)
        begin
            case (cur_reg.op)
                CMD_READ:  data_reg[slot_reg] <= fill_word;
                CMD_WRITE: data_reg[slot_reg] <= cur_reg.data;
                default:   data_reg[slot_reg] <= '0;
            endcase
            out_reg.read_data  <= (cur_reg.op == CMD_READ) ? fill_word : '0;
            out_reg.hit        <= hit_reg;
            out_reg.evicted    <= evict_reg;
            out_reg.sync_count <= '0;
        end
        if (state_reg == ST_SYNC && load_out)
        begin
            out_reg.read_data      <= '0;
            out_reg.hit            <= 1'b0;
            out_reg.evicted        <= 1'b0;
            out_reg.victim_id      <= '0;
            out_reg.victim_written <= 1'b0;
            out_reg.sync_count     <= sync_final;
        end
    end

    assign wiping    = (state_reg == ST_WIPE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lru_write_back_block_cache.sv
// lru write-back block cache: read, write and clear pass the queue, lookup, update and
// fill steps before raising out_valid; sync walks every line, one line a cycle.
// the back starts an item only once the previous result is taken, so it takes no new
// item before it is through with the last one. after reset a wipe pass zeros the
// whole backing store with in_stall high; config writes are always taken.
// depends on lwbc_pkg, lwbc_front, lwbc_back
`default_nettype none

module lru_write_back_block_cache #(
    parameter int CACHE_LINES = lwbc_pkg::CACHE_LINES_DF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire lwbc_pkg::in_item_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output lwbc_pkg::out_item_t                out_data,
    input  wire logic                          cfg_we,
    input  wire logic [lwbc_pkg::CFG_BITS-1:0] cfg_wdata
);
    import lwbc_pkg::*;

    logic [CFG_BITS-1:0] lines_reg;
    qhead_t              head;
    logic                pop;
    logic                wiping;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lines_reg <= LINES_RESET;
        else if (cfg_we)
            lines_reg <= cfg_wdata;
    end

    lwbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .wiping   (wiping),
        .pop      (pop),
        .head     (head)
    );

    lwbc_back #(
        .CACHE_LINES (CACHE_LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .wiping    (wiping),
        .lines_cfg (lines_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lwbc_checker.sv
// lwbc_checker: port-level checks of the block cache result channel, bound to the top
// depends on lwbc_pkg and lru_write_back_block_cache
`default_nettype none

module lwbc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire lwbc_pkg::out_item_t out_data
);
    import lwbc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sync_count != '0 |->
            !out_data.hit && !out_data.evicted && out_data.read_data == '0)
        else $error("sync beat carries lookup fields");

    a_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.evicted |->
            out_data.victim_id == '0 && !out_data.victim_written)
        else $error("victim fields set without eviction");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> !out_data.evicted)
        else $error("hit beat reports an eviction");

endmodule

bind lru_write_back_block_cache lwbc_checker u_lwbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
